// ----- rtl/irp_pkg.sv -----
// Shared types, token codes, microcode table and helper functions of the postfix reorder unit.
package irp_pkg;

    localparam int KindW         = 5;
    localparam int PayloadW      = 64;
    localparam int StackDepthDef = 32;

    typedef logic [KindW-1:0]    t_kind;
    typedef logic [PayloadW-1:0] t_payload;
    typedef logic [2:0]          t_prec;

    // Token codes
    localparam t_kind K_ADD   = 5'd0;
    localparam t_kind K_SUB   = 5'd1;
    localparam t_kind K_MUL   = 5'd2;
    localparam t_kind K_DIV   = 5'd3;
    localparam t_kind K_POW   = 5'd4;
    localparam t_kind K_FN_LO = 5'd5;
    localparam t_kind K_FN_HI = 5'd16;
    localparam t_kind K_LPAR  = 5'd17;
    localparam t_kind K_RPAR  = 5'd18;
    localparam t_kind K_EQ    = 5'd19;
    localparam t_kind K_NEG   = 5'd20;
    localparam t_kind K_NUM   = 5'd21;
    localparam t_kind K_VAR   = 5'd22;
    localparam t_kind K_END   = 5'd23;

    // Precedence levels
    localparam t_prec P_EQ    = 3'd0;
    localparam t_prec P_ADD   = 3'd1;
    localparam t_prec P_MUL   = 3'd2;
    localparam t_prec P_POW   = 3'd3;
    localparam t_prec P_UNARY = 3'd4;
    localparam t_prec P_LPAR  = 3'd5;

    typedef enum logic [1:0] {
        F_OK       = 2'd0,
        F_OVERFLOW = 2'd1,
        F_RPAR     = 2'd2,
        F_LPAR     = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        CL_OPND,
        CL_PUSH,
        CL_BIN,
        CL_RPAR,
        CL_END,
        CL_NONE
    } t_class;

    // Microprogram addresses
    typedef enum logic [3:0] {
        S_IDLE,
        S_OPND,
        S_PUSH,
        S_TESTB,
        S_WAITB,
        S_TESTR,
        S_WAITR,
        S_TESTE,
        S_WAITE
    } t_step;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_DISPATCH,
        C_BSTOP,
        C_RDONE,
        C_EMPTY
    } t_cond;

    // Datapath operations
    typedef enum logic [2:0] {
        U_NONE,
        U_EMIT_TOK,
        U_PUSH,
        U_EMIT_POP,
        U_RP_CLOSE,
        U_EMIT_END,
        U_END_POP
    } t_uop;

    // One control word: op_t and jmp when the condition holds, op_f and nxt otherwise
    typedef struct packed {
        t_cond cond;
        t_uop  op_t;
        t_step jmp;
        t_uop  op_f;
        t_step nxt;
    } t_uword;

    // Stack command and status
    typedef struct packed {
        logic  push;
        logic  pop;
        t_kind wdata;
    } t_stk_cmd;

    typedef struct packed {
        logic  empty;
        logic  full;
        t_kind top;
    } t_stk_stat;

    // Emit request into the holding stage
    typedef struct packed {
        logic     valid;
        t_kind    kind;
        t_payload payload;
        t_fault   fault;
    } t_emit_req;

    typedef struct packed {
        logic can_emit;
    } t_emit_stat;

    function automatic logic f_is_unary(t_kind k);
        return (k >= K_FN_LO && k <= K_FN_HI) || k == K_NEG;
    endfunction

    function automatic logic f_is_binary(t_kind k);
        return k <= K_POW || k == K_EQ;
    endfunction

    function automatic t_prec f_prec(t_kind k);
        t_prec p;
        if (k == K_EQ)          p = P_EQ;
        else if (k <= K_SUB)    p = P_ADD;
        else if (k <= K_DIV)    p = P_MUL;
        else if (k == K_POW)    p = P_POW;
        else if (f_is_unary(k)) p = P_UNARY;
        else                    p = P_LPAR;
        return p;
    endfunction

    // True when stacked token t must be popped before binary token k is pushed
    function automatic logic f_pops(t_kind t, t_kind k);
        t_prec pt;
        t_prec pk;
        pt = f_prec(t);
        pk = f_prec(k);
        return (t != K_LPAR) &&
               (f_is_unary(t) || pt > pk || (pt == pk && k != K_POW));
    endfunction

    function automatic t_class f_class(t_kind k);
        t_class c;
        if (k == K_NUM || k == K_VAR)          c = CL_OPND;
        else if (f_is_unary(k) || k == K_LPAR) c = CL_PUSH;
        else if (f_is_binary(k))               c = CL_BIN;
        else if (k == K_RPAR)                  c = CL_RPAR;
        else if (k == K_END)                   c = CL_END;
        else                                   c = CL_NONE;
        return c;
    endfunction

    // Dispatch table: entry point of each token class
    function automatic t_step f_entry(t_class c);
        t_step s;
        unique case (c)
            CL_OPND: s = S_OPND;
            CL_PUSH: s = S_PUSH;
            CL_BIN:  s = S_TESTB;
            CL_RPAR: s = S_TESTR;
            CL_END:  s = S_TESTE;
            default: s = S_IDLE;
        endcase
        return s;
    endfunction

    // Microprogram ROM
    function automatic t_uword f_ucode(t_step s);
        t_uword w;
        unique case (s)
            S_IDLE:  w = '{C_DISPATCH, U_NONE,     S_IDLE,  U_NONE,     S_IDLE};
            S_OPND:  w = '{C_NEVER,    U_NONE,     S_IDLE,  U_EMIT_TOK, S_IDLE};
            S_PUSH:  w = '{C_NEVER,    U_NONE,     S_IDLE,  U_PUSH,     S_IDLE};
            S_TESTB: w = '{C_BSTOP,    U_NONE,     S_PUSH,  U_EMIT_POP, S_WAITB};
            S_WAITB: w = '{C_NEVER,    U_NONE,     S_IDLE,  U_NONE,     S_TESTB};
            S_TESTR: w = '{C_RDONE,    U_RP_CLOSE, S_IDLE,  U_EMIT_POP, S_WAITR};
            S_WAITR: w = '{C_NEVER,    U_NONE,     S_IDLE,  U_NONE,     S_TESTR};
            S_TESTE: w = '{C_EMPTY,    U_EMIT_END, S_IDLE,  U_END_POP,  S_WAITE};
            S_WAITE: w = '{C_NEVER,    U_NONE,     S_IDLE,  U_NONE,     S_TESTE};
            default: w = '{C_NEVER,    U_NONE,     S_IDLE,  U_NONE,     S_IDLE};
        endcase
        return w;
    endfunction

    // Operations that may place a word into the holding stage
    function automatic logic f_may_emit(t_uop u);
        return u == U_EMIT_TOK || u == U_PUSH || u == U_EMIT_POP ||
               u == U_RP_CLOSE || u == U_EMIT_END || u == U_END_POP;
    endfunction

endpackage

// ----- rtl/irp_if.sv -----
// Token and result channel interfaces of the postfix reorder unit.
interface irp_tok_if;
    logic                  valid;
    logic                  ready;
    logic [irp_pkg::KindW-1:0]    kind;
    logic [irp_pkg::PayloadW-1:0] payload;

    modport source (output valid, output kind, output payload, input ready);
    modport sink   (input valid, input kind, input payload, output ready);
endinterface

interface irp_res_if;
    logic                  valid;
    logic                  ready;
    logic [irp_pkg::KindW-1:0]    out_kind;
    logic [irp_pkg::PayloadW-1:0] out_payload;
    logic                  run_last;
    logic [1:0]            fault;

    modport source (output valid, output out_kind, output out_payload, output run_last,
                    output fault, input ready);
    modport sink   (input valid, input out_kind, input out_payload, input run_last,
                    input fault, output ready);
endinterface

// ----- rtl/infix_to_postfix_reorder.sv -----
// Top level of the infix-to-postfix reorder unit.
//
//  channel  | dir | words                                     | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_tok    | in  | kind, payload                             | valid/ready
//  o_res    | out | out_kind, out_payload, run_last, fault    | valid/ready
//
// An operand or a push runs a single step; a binary operator, a right paren or end
// runs a test step and pops stacked entries, with a wait step after each pop, set by the
// stack memory's registered read port that must settle after each pop; an unknown
// code goes straight back to idle.
// Reset is synchronous: it clears the step counter, stack count and valid flags;
// stack contents are left unwritten and need no clearing pass.
// A result word waits in a holding stage and the output register; the sequencer
// stalls only when both are full and o_res.ready is low, and takes the next token while one waits.
module infix_to_postfix_reorder #(
    parameter int STACK_DEPTH = irp_pkg::StackDepthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irp_tok_if.sink   i_tok,
    irp_res_if.source o_res
);
    irp_pkg::t_stk_cmd   stk_cmd;
    irp_pkg::t_stk_stat  stk_stat;
    irp_pkg::t_emit_req  emit_req;
    irp_pkg::t_emit_stat emit_stat;
    logic                flush;

    irp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (i_tok),
        .i_stk   (stk_stat),
        .i_emit  (emit_stat),
        .o_stk   (stk_cmd),
        .o_req   (emit_req),
        .o_flush (flush)
    );

    irp_stack #(
        .Depth (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    irp_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .i_flush (flush),
        .o_stat  (emit_stat),
        .o_res   (o_res)
    );
endmodule

// ----- rtl/irp_stack.sv -----
// Operator stack: memory with registered top-of-stack read and an entry count.
module irp_stack #(
    parameter int Depth = irp_pkg::StackDepthDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irp_pkg::t_stk_cmd  i_cmd,
    output irp_pkg::t_stk_stat o_stat
);
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    irp_pkg::t_kind r_mem [Depth];
    irp_pkg::t_kind r_top;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic [AddrW-1:0] rd_addr;
    logic [CntW-1:0] cnt_m1;

    // Point the read port at the top entry
    always_comb begin
        cnt_m1  = r_count - 1'b1;
        rd_addr = (r_count == '0) ? '0 : cnt_m1[AddrW-1:0];
    end

    // Write on push, read the top every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AddrW-1:0]] <= i_cmd.wdata;
        end
        r_top <= r_mem[rd_addr];
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (i_cmd.push)     n_count = r_count + 1'b1;
        else if (i_cmd.pop) n_count = cnt_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(Depth));
    assign o_stat.top   = r_top;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_stat.full)
        else $error("push onto a full stack");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_stat.empty)
        else $error("pop from an empty stack");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop in one cycle");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("stack count past depth");
endmodule

// ----- rtl/irp_emit.sv -----
// Result path: holding stage that settles the last-word flag, then the output register.
module irp_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irp_pkg::t_emit_req  i_req,
    input  logic                i_flush,
    output irp_pkg::t_emit_stat o_stat,
    irp_res_if.source           o_res
);
    irp_pkg::t_kind    r_pend_kind;
    irp_pkg::t_payload r_pend_payload;
    irp_pkg::t_fault   r_pend_fault;
    logic              r_pend_v;

    irp_pkg::t_kind    r_out_kind;
    irp_pkg::t_payload r_out_payload;
    irp_pkg::t_fault   r_out_fault;
    logic              r_out_last;
    logic              r_out_v;

    logic out_free;
    logic load_out;

    // Move the held word out when a newer word arrives or the item ends
    assign out_free = !r_out_v || o_res.ready;
    assign load_out = r_pend_v && out_free && (i_req.valid || i_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_req.valid)   r_pend_v <= 1'b1;
            else if (load_out) r_pend_v <= 1'b0;
            if (load_out)         r_out_v <= 1'b1;
            else if (o_res.ready) r_out_v <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_pend_kind    <= i_req.kind;
            r_pend_payload <= i_req.payload;
            r_pend_fault   <= i_req.fault;
        end
        if (load_out) begin
            r_out_kind    <= r_pend_kind;
            r_out_payload <= r_pend_payload;
            r_out_fault   <= r_pend_fault;
            r_out_last    <= !i_req.valid;
        end
    end

    assign o_stat.can_emit = !r_pend_v || out_free;

    assign o_res.valid       = r_out_v;
    assign o_res.out_kind    = r_out_kind;
    assign o_res.out_payload = r_out_payload;
    assign o_res.run_last    = r_out_last;
    assign o_res.fault       = r_out_fault;

    a_req_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> (!r_pend_v || out_free))
        else $error("word emitted with no room in the result path");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_flush && !i_req.valid && r_pend_v && out_free) |=> !r_pend_v && r_out_v)
        else $error("held word not moved out at the end of an item");
endmodule

// ----- rtl/irp_seq.sv -----
// Microcoded sequencer: step counter, control-word decode, token register and jumps.
module irp_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    irp_tok_if.sink             i_tok,
    input  irp_pkg::t_stk_stat  i_stk,
    input  irp_pkg::t_emit_stat i_emit,
    output irp_pkg::t_stk_cmd   o_stk,
    output irp_pkg::t_emit_req  o_req,
    output logic                o_flush
);
    irp_pkg::t_step    r_pc;
    irp_pkg::t_step    n_pc;
    irp_pkg::t_kind    r_kind;
    irp_pkg::t_payload r_payload;
    logic              r_open;
    logic              n_open;

    irp_pkg::t_uword uw;
    irp_pkg::t_uop   op;
    irp_pkg::t_step  target;
    logic            hit;
    logic            stall;
    logic            idle;
    logic            accept;
    logic            top_lpar;

    // Fetch the control word and evaluate its condition
    always_comb begin
        uw       = irp_pkg::f_ucode(r_pc);
        top_lpar = (i_stk.top == irp_pkg::K_LPAR);
        unique case (uw.cond)
            irp_pkg::C_BSTOP: hit = i_stk.empty || top_lpar ||
                                    !irp_pkg::f_pops(i_stk.top, r_kind);
            irp_pkg::C_RDONE: hit = i_stk.empty || top_lpar;
            irp_pkg::C_EMPTY: hit = i_stk.empty;
            default:          hit = 1'b0;
        endcase
        op     = hit ? uw.op_t : uw.op_f;
        target = hit ? uw.jmp : uw.nxt;
        stall  = irp_pkg::f_may_emit(op) && !i_emit.can_emit;
    end

    assign idle        = (r_pc == irp_pkg::S_IDLE);
    assign i_tok.ready = idle && i_emit.can_emit;
    assign accept      = i_tok.valid && i_tok.ready;
    assign o_flush     = idle;

    // Decode the operation into stack and emit commands
    always_comb begin
        o_stk         = '0;
        o_stk.wdata   = r_kind;
        o_req         = '0;
        o_req.kind    = r_kind;
        o_req.fault   = irp_pkg::F_OK;
        n_open        = r_open;
        if (!stall) begin
            unique case (op)
                irp_pkg::U_EMIT_TOK: begin
                    o_req.valid   = 1'b1;
                    o_req.payload = r_payload;
                end
                irp_pkg::U_PUSH: begin
                    if (i_stk.full) begin
                        o_req.valid = 1'b1;
                        o_req.fault = irp_pkg::F_OVERFLOW;
                    end else begin
                        o_stk.push = 1'b1;
                    end
                end
                irp_pkg::U_EMIT_POP: begin
                    o_req.valid = 1'b1;
                    o_req.kind  = i_stk.top;
                    o_stk.pop   = 1'b1;
                end
                irp_pkg::U_RP_CLOSE: begin
                    if (i_stk.empty) begin
                        o_req.valid = 1'b1;
                        o_req.kind  = irp_pkg::K_RPAR;
                        o_req.fault = irp_pkg::F_RPAR;
                    end else begin
                        o_stk.pop = 1'b1;
                    end
                end
                irp_pkg::U_EMIT_END: begin
                    o_req.valid = 1'b1;
                    o_req.kind  = irp_pkg::K_END;
                    o_req.fault = r_open ? irp_pkg::F_LPAR : irp_pkg::F_OK;
                    n_open      = 1'b0;
                end
                irp_pkg::U_END_POP: begin
                    o_stk.pop = 1'b1;
                    if (top_lpar) begin
                        n_open = 1'b1;
                    end else begin
                        o_req.valid = 1'b1;
                        o_req.kind  = i_stk.top;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next step: dispatch from idle, hold on stall, else follow the jump
    always_comb begin
        if (idle)       n_pc = accept ? irp_pkg::f_entry(irp_pkg::f_class(i_tok.kind))
                                      : irp_pkg::S_IDLE;
        else if (stall) n_pc = r_pc;
        else            n_pc = target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= irp_pkg::S_IDLE;
            r_open <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_open <= n_open;
        end
    end

    // Latch the accepted token
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_tok.kind;
            r_payload <= i_tok.payload;
        end
    end

    a_idle_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle |-> !o_req.valid && !o_stk.push && !o_stk.pop)
        else $error("datapath command issued from the idle step");
endmodule
